[rtl/core/ptc_pkg.sv]
// Package for the pointer cursor tracker: widths, reset values, register indexes and states.
package ptc_pkg;

  // Default cursor coordinate width.
  localparam int POS_BITS_DEF = 13;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Field widths fixed by the report formats.
  localparam int COORD_W  = 16;
  localparam int SCREEN_W = 14;
  localparam int SPEED_W  = 6;

  // A relative product is at most 16 + 6 bits wide; the divider's low shift
  // register holds that many bits.
  localparam int REL_BITS = COORD_W + SPEED_W;

  // Register reset values.
  localparam logic [SCREEN_W-1:0] SCREEN_W_RST = 14'd1024;
  localparam logic [SCREEN_W-1:0] SCREEN_H_RST = 14'd768;
  localparam logic [SPEED_W-1:0]  SPEED_RST    = 6'd4;
  localparam logic [COORD_W-1:0]  ABS_MAX_RST  = 16'hFFFF;
  localparam logic [COORD_W-1:0]  REL_RES_RST  = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_MOUSE_SPEED   = 3'd2,
    CFG_ABS_MAX_X     = 3'd3,
    CFG_ABS_MAX_Y     = 3'd4,
    CFG_REL_RES_X     = 3'd5,
    CFG_REL_RES_Y     = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_AXIS_END,
    ST_DONE
  } ptc_state_t;

endpackage

[rtl/core/pointer_cursor_tracker_core.sv]
// Pointer cursor tracker: scales touch reports and integrates mouse motion into a cursor position.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  in      | input     | in_valid/in_stall  | abs_valid abs_x abs_y touch_active rel_valid
//          |           |                    | rel_dx rel_dy left_button
//  out     | output    | out_valid/out_stall| status cursor_x cursor_y holding press
//  cfg     | input     | cfg_wr_en          | cfg_index cfg_data
//
// One multiplier and one restoring divider (one quotient bit per cycle) are shared by both
// axes under a small sequencer. Each axis runs a multiply step, K divide steps and a clamp
// step, with K = POS_BITS for a touch report and 22 for a mouse report; the divide is
// skipped when a touch coordinate is at or past full scale or a mouse divisor is zero.
// An item with no report goes straight to the result. The block takes no new beat while
// an item is in work. Reset is synchronous: it loads the register defaults and centers the
// cursor. The result beat sits in an output register, so a stalled output only holds the
// sequencer in its final state.
module pointer_cursor_tracker_core
  import ptc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Poll beats.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  abs_valid,
  input  logic [COORD_W-1:0]    abs_x,
  input  logic [COORD_W-1:0]    abs_y,
  input  logic                  touch_active,
  input  logic                  rel_valid,
  input  logic signed [COORD_W-1:0] rel_dx,
  input  logic signed [COORD_W-1:0] rel_dy,
  input  logic                  left_button,
  // Result beats.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  status,
  output logic [POS_BITS-1:0]   cursor_x,
  output logic [POS_BITS-1:0]   cursor_y,
  output logic                  holding,
  output logic                  press
);

  // Product of a 16-bit operand and an effective screen size of POS_BITS+1 bits.
  localparam int PROD_W = COORD_W + POS_BITS + 1;
  // Clamp arithmetic: position plus or minus a 22-bit quotient, with a sign bit on top.
  localparam int SUM_W  = REL_BITS + 2;
  localparam int CNT_W  = $clog2(REL_BITS + 1);
  localparam logic [16:0] SIZE_LIM = 17'(2 ** POS_BITS);

  // The effective screen size is the register limited to [1, 2^POS_BITS].
  function automatic logic [POS_BITS:0] eff_size(input logic [SCREEN_W-1:0] s);
    logic [16:0] s_ext;
    s_ext = 17'(s);
    if (s == '0) begin
      eff_size = (POS_BITS+1)'(1);
    end else if (s_ext > SIZE_LIM) begin
      eff_size = SIZE_LIM[POS_BITS:0];
    end else begin
      eff_size = s_ext[POS_BITS:0];
    end
  endfunction

  localparam logic [POS_BITS:0]   RST_W_X   = eff_size(SCREEN_W_RST);
  localparam logic [POS_BITS:0]   RST_W_Y   = eff_size(SCREEN_H_RST);
  localparam logic [POS_BITS-1:0] POS_X_RST = POS_BITS'(RST_W_X >> 1);
  localparam logic [POS_BITS-1:0] POS_Y_RST = POS_BITS'(RST_W_Y >> 1);

  // Configuration registers.
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;
  logic [SPEED_W-1:0]  mouse_speed;
  logic [COORD_W-1:0]  abs_max_x;
  logic [COORD_W-1:0]  abs_max_y;
  logic [COORD_W-1:0]  rel_res_x;
  logic [COORD_W-1:0]  rel_res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_W_RST;
      screen_height <= SCREEN_H_RST;
      mouse_speed   <= SPEED_RST;
      abs_max_x     <= ABS_MAX_RST;
      abs_max_y     <= ABS_MAX_RST;
      rel_res_x     <= REL_RES_RST;
      rel_res_y     <= REL_RES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[SCREEN_W-1:0];
        CFG_MOUSE_SPEED:   mouse_speed   <= cfg_data[SPEED_W-1:0];
        CFG_ABS_MAX_X:     abs_max_x     <= cfg_data;
        CFG_ABS_MAX_Y:     abs_max_y     <= cfg_data;
        CFG_REL_RES_X:     rel_res_x     <= cfg_data;
        CFG_REL_RES_Y:     rel_res_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and the item captured at acceptance.
  ptc_state_t state, state_next;

  logic                 item_abs;    // touch report wins over the mouse report
  logic                 item_any;    // some report was present
  logic                 item_hold;   // new hold state
  logic [COORD_W-1:0]   raw_x;       // touch coordinate or mouse delta
  logic [COORD_W-1:0]   raw_y;
  logic                 axis;        // 0 works on X, 1 on Y
  logic                 skip;        // divide bypassed for this axis
  logic [CNT_W-1:0]     cnt;

  // Architectural state.
  logic [POS_BITS-1:0]  pos_x;
  logic [POS_BITS-1:0]  pos_y;
  logic                 held;

  // Shared arithmetic.
  logic [COORD_W-1:0]   div_rem;
  logic [REL_BITS-1:0]  div_lo;

  // Sequencer controls.
  logic accept, do_mul, do_div, do_axis_end, do_load;

  // Per-axis operand selection.
  logic [COORD_W-1:0]   cur_raw;
  logic [COORD_W-1:0]   cur_mag;
  logic [POS_BITS:0]    w_x, w_y, w_cur;
  logic [POS_BITS-1:0]  w_max;
  logic [COORD_W-1:0]   divisor;
  logic                 skip_now;
  logic [COORD_W-1:0]   mul_a;
  logic [POS_BITS:0]    mul_b;
  logic [PROD_W-1:0]    prod;

  assign w_x     = eff_size(screen_width);
  assign w_y     = eff_size(screen_height);
  assign w_cur   = axis ? w_y : w_x;
  assign w_max   = POS_BITS'(w_cur - (POS_BITS+1)'(1));
  assign cur_raw = axis ? raw_y : raw_x;
  assign cur_mag = cur_raw[COORD_W-1] ? (COORD_W'(0) - cur_raw) : cur_raw;

  always_comb begin
    if (item_abs) begin
      divisor = axis ? abs_max_y : abs_max_x;
    end else begin
      divisor = axis ? rel_res_y : rel_res_x;
    end
  end

  // A touch coordinate at or past full scale (which covers a zero full scale) lands on the
  // last pixel without a divide; a zero mouse divisor means no movement.
  assign skip_now = item_abs ? (cur_raw >= divisor) : (divisor == '0);

  assign mul_a = item_abs ? cur_raw : cur_mag;
  assign mul_b = item_abs ? w_cur : (POS_BITS+1)'(mouse_speed);
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One restoring divide step: bring in the next dividend bit, subtract if it fits.
  logic [COORD_W:0]   div_shift;
  logic [COORD_W:0]   div_diff;
  logic               div_fit;

  assign div_shift = {div_rem, div_lo[REL_BITS-1]};
  assign div_diff  = div_shift - {1'b0, divisor};
  assign div_fit   = div_shift >= {1'b0, divisor};

  // Clamp of the new coordinate for the current axis.
  logic [POS_BITS-1:0]  pos_cur;
  logic [REL_BITS-1:0]  quot;
  logic [SUM_W-1:0]     sum;
  logic [POS_BITS-1:0]  new_pos;

  assign pos_cur = axis ? pos_y : pos_x;
  assign quot    = skip ? '0 : div_lo;
  assign sum     = cur_raw[COORD_W-1] ? (SUM_W'(pos_cur) - SUM_W'(quot))
                                      : (SUM_W'(pos_cur) + SUM_W'(quot));

  always_comb begin
    if (item_abs) begin
      new_pos = skip ? w_max : div_lo[POS_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      new_pos = '0;
    end else if (sum >= SUM_W'(w_cur)) begin
      new_pos = w_max;
    end else begin
      new_pos = sum[POS_BITS-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (abs_valid || rel_valid) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        state_next = skip_now ? ST_AXIS_END : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ST_AXIS_END;
        end
      end
      ST_AXIS_END: begin
        state_next = axis ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    accept      = 1'b0;
    do_mul      = 1'b0;
    do_div      = 1'b0;
    do_axis_end = 1'b0;
    do_load     = 1'b0;
    in_stall    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_MUL:      do_mul      = 1'b1;
      ST_DIV:      do_div      = 1'b1;
      ST_AXIS_END: do_axis_end = 1'b1;
      ST_DONE:     do_load     = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured item; the report type decides which coordinates and button are kept.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_abs  <= abs_valid;
      item_any  <= abs_valid || rel_valid;
      item_hold <= abs_valid ? touch_active : left_button;
      raw_x     <= abs_valid ? abs_x : rel_dx;
      raw_y     <= abs_valid ? abs_y : rel_dy;
    end
  end

  // Axis select and divide counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= 1'b0;
      skip <= 1'b0;
      cnt  <= '0;
    end else begin
      if (accept) begin
        axis <= 1'b0;
      end else if (do_axis_end) begin
        axis <= 1'b1;
      end
      if (do_mul) begin
        skip <= skip_now;
        cnt  <= item_abs ? CNT_W'(POS_BITS) : CNT_W'(REL_BITS);
      end else if (do_div) begin
        cnt  <= cnt - CNT_W'(1);
      end
    end
  end

  // The product loads the divider. For a touch report the quotient is known to stay below
  // 2^POS_BITS, so the upper product bits start as the partial remainder and only POS_BITS
  // steps remain; the low bits are left-aligned so both cases shift out of the same end.
  always_ff @(posedge clk) begin
    if (do_mul) begin
      if (item_abs) begin
        div_rem <= prod[POS_BITS+COORD_W-1:POS_BITS];
        div_lo  <= {prod[POS_BITS-1:0], {(REL_BITS-POS_BITS){1'b0}}};
      end else begin
        div_rem <= '0;
        div_lo  <= prod[REL_BITS-1:0];
      end
    end else if (do_div) begin
      div_rem <= div_fit ? div_diff[COORD_W-1:0] : div_shift[COORD_W-1:0];
      div_lo  <= {div_lo[REL_BITS-2:0], div_fit};
    end
  end

  // Position and hold state. Configuration writes never move the cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= POS_X_RST;
      pos_y <= POS_Y_RST;
      held  <= 1'b0;
    end else begin
      if (do_axis_end) begin
        if (axis) begin
          pos_y <= new_pos;
        end else begin
          pos_x <= new_pos;
        end
      end
      if (do_load && item_any) begin
        held <= item_hold;
      end
    end
  end

  // Output register. A press beat marks the release of a hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      status   <= !item_any;
      cursor_x <= pos_x;
      cursor_y <= pos_y;
      holding  <= item_any ? item_hold : held;
      press    <= item_any && held && !item_hold;
    end
  end

endmodule

[rtl/core/ptc_checker.sv]
// Port-level checks for the pointer cursor tracker and their binding to the top level.
module ptc_checker
  import ptc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      abs_valid,
  input logic [COORD_W-1:0]        abs_x,
  input logic [COORD_W-1:0]        abs_y,
  input logic                      touch_active,
  input logic                      rel_valid,
  input logic signed [COORD_W-1:0] rel_dx,
  input logic signed [COORD_W-1:0] rel_dy,
  input logic                      left_button,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      status,
  input logic [POS_BITS-1:0]       cursor_x,
  input logic [POS_BITS-1:0]       cursor_y,
  input logic                      holding,
  input logic                      press
);

  // A beat held back on the output stays there unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable({status, cursor_x, cursor_y, holding, press}))
    else $error("result beat dropped or changed while stalled");

  // A poll beat held back on the input stays there unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=>
      in_valid && $stable({abs_valid, abs_x, abs_y, touch_active, rel_valid,
                           rel_dx, rel_dy, left_button}))
    else $error("poll beat dropped or changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // A release pulse never comes with the hold still on.
  a_press_release: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press && holding))
    else $error("press reported while holding");

  // Without a report nothing can be released.
  a_idle_no_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !press)
    else $error("press reported on a poll without a report");

endmodule

bind pointer_cursor_tracker_core ptc_checker #(.POS_BITS(POS_BITS)) u_ptc_checker (.*);
